>>> hdl/mf_pkg.sv
// Shared types and constants for the message fragmenter.
`default_nettype none
package mf_pkg;
	localparam int MTU            = 29;
	localparam int MESSAGE_BUFFER = 256;
	localparam logic [7:0] NEWLINE_BYTE = 8'h0A;

	localparam int FILL_W = $clog2(MTU + 1);
	localparam int ADDR_W = (MTU > 1) ? $clog2(MTU) : 1;
	localparam int CNT_W  = (MESSAGE_BUFFER > 2) ? $clog2(MESSAGE_BUFFER) : 1;
	localparam int LEN_W  = 5;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       last_byte;
		logic       empty_message;
	} in_item_t;

	typedef struct packed {
		logic [7:0]       out_byte;
		logic [7:0]       seq_number;
		logic             frag_start;
		logic             frag_more;
		logic             frag_end;
		logic [LEN_W-1:0] chunk_length;
		logic             end_of_frame;
		logic             last_of_run;
	} out_item_t;

	typedef struct packed {
		logic in_ready;
		logic wr;
		logic to_nl;
		logic set_more;
		logic more_val;
		logic start_rd;
		logic next_rd;
		logic load_out;
		logic emit_done;
	} cmd_t;

	typedef struct packed {
		logic acc;
		logic keep_now;
		logic finish_now;
		logic full;
		logic nl;
		logic finish;
		logic more;
		logic idx_last;
		logic out_free;
	} sts_t;
endpackage
`default_nettype wire

>>> hdl/mf_in_if.sv
// Request channel carrying message bytes into the fragmenter.
`default_nettype none
interface mf_in_if;
	import mf_pkg::*;
	logic     valid;
	logic     ready;
	in_item_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface
`default_nettype wire

>>> hdl/mf_out_if.sv
// Request channel carrying frame payload bytes out of the fragmenter.
`default_nettype none
interface mf_out_if;
	import mf_pkg::*;
	logic      valid;
	logic      ready;
	out_item_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface
`default_nettype wire

>>> hdl/mf_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module mf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 29,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule
`default_nettype wire

>>> hdl/mf_ctrl.sv
// Controller state machine sequencing byte pushes and frame emission.
`default_nettype none
module mf_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire mf_pkg::sts_t  sts,
	output mf_pkg::cmd_t       cmd
);
	import mf_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE  = 4'b0001,
		S_PUSH  = 4'b0010,
		S_START = 4'b0100,
		S_EMIT  = 4'b1000
	} state_t;

	state_t state_q, state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		cmd       = '0;
		state_nxt = state_q;
		case (state_q)
			S_IDLE: begin
				cmd.in_ready = 1'b1;
				if (sts.acc && (sts.keep_now || sts.finish_now)) begin
					state_nxt = S_PUSH;
				end
			end
			S_PUSH: begin
				if (sts.full) begin
					cmd.set_more = 1'b1;
					cmd.more_val = 1'b1;
					state_nxt    = S_START;
				end else begin
					cmd.wr = 1'b1;
					if (!sts.nl && sts.finish) begin
						cmd.to_nl = 1'b1;
					end else if (sts.nl) begin
						cmd.set_more = 1'b1;
						cmd.more_val = 1'b0;
						state_nxt    = S_START;
					end else begin
						state_nxt = S_IDLE;
					end
				end
			end
			S_START: begin
				cmd.start_rd = 1'b1;
				state_nxt    = S_EMIT;
			end
			S_EMIT: begin
				if (sts.out_free) begin
					cmd.load_out = 1'b1;
					if (!sts.idx_last) begin
						cmd.next_rd = 1'b1;
					end else begin
						cmd.emit_done = 1'b1;
						state_nxt     = sts.more ? S_PUSH : S_IDLE;
					end
				end
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

`ifndef SYNTHESIS
	a_accept_idle: assert property (@(posedge clk) disable iff (!arst_n)
		sts.acc |-> state_q == S_IDLE)
		else $error("input accepted outside idle");
	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> sts.out_free)
		else $error("output register overwritten");
	a_start_emit: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.start_rd |=> state_q == S_EMIT)
		else $error("read start not followed by emission");
`endif
endmodule
`default_nettype wire

>>> hdl/mf_dp.sv
// Datapath: frame store, fill and message counters, sequence and output register.
`default_nettype none
module mf_dp (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire mf_pkg::cmd_t cmd,
	output mf_pkg::sts_t      sts,
	mf_in_if.sink             in_ch,
	mf_out_if.source          out_ch
);
	import mf_pkg::*;

	logic [FILL_W-1:0] fill_q;
	logic [CNT_W-1:0]  count_q;
	logic [7:0]        seq_q;
	logic              first_q;
	logic [7:0]        pb_q;
	logic              nl_q;
	logic              finish_q;
	logic              more_q;
	logic [ADDR_W-1:0] idx_q;
	logic              ov_q;
	out_item_t         out_q;

	logic              acc;
	logic              keep_now;
	logic              idx_last;
	logic [ADDR_W-1:0] raddr;
	logic [7:0]        rdata;

	assign in_ch.ready = cmd.in_ready;
	assign acc         = in_ch.valid && cmd.in_ready;
	assign keep_now    = !in_ch.data.empty_message && (count_q < CNT_W'(MESSAGE_BUFFER - 1));
	assign idx_last    = (FILL_W'(idx_q) + FILL_W'(1)) == fill_q;
	assign raddr       = cmd.start_rd ? '0 : idx_q + ADDR_W'(1);

	assign sts.acc        = acc;
	assign sts.keep_now   = keep_now;
	assign sts.finish_now = in_ch.data.empty_message || in_ch.data.last_byte;
	assign sts.full       = fill_q == FILL_W'(MTU);
	assign sts.nl         = nl_q;
	assign sts.finish     = finish_q;
	assign sts.more       = more_q;
	assign sts.idx_last   = idx_last;
	assign sts.out_free   = !ov_q || out_ch.ready;

	mf_ram #(.WIDTH(8), .DEPTH(MTU)) u_store (
		.clk   (clk),
		.we    (cmd.wr),
		.waddr (ADDR_W'(fill_q)),
		.wdata (pb_q),
		.re    (cmd.start_rd || cmd.next_rd),
		.raddr (raddr),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q   <= '0;
			count_q  <= '0;
			seq_q    <= '0;
			first_q  <= 1'b1;
			nl_q     <= 1'b0;
			finish_q <= 1'b0;
			more_q   <= 1'b0;
			idx_q    <= '0;
			ov_q     <= 1'b0;
		end else begin
			if (acc) begin
				nl_q     <= !keep_now;
				finish_q <= in_ch.data.empty_message || in_ch.data.last_byte;
				if (keep_now) begin
					count_q <= count_q + CNT_W'(1);
				end
			end
			if (cmd.wr) begin
				fill_q <= fill_q + FILL_W'(1);
			end
			if (cmd.to_nl) begin
				nl_q <= 1'b1;
			end
			if (cmd.set_more) begin
				more_q <= cmd.more_val;
			end
			if (cmd.start_rd) begin
				idx_q <= '0;
			end else if (cmd.next_rd) begin
				idx_q <= idx_q + ADDR_W'(1);
			end
			if (cmd.emit_done) begin
				seq_q  <= seq_q + 8'd1;
				fill_q <= '0;
				if (more_q) begin
					first_q <= 1'b0;
				end else begin
					first_q <= 1'b1;
					count_q <= '0;
				end
			end
			if (cmd.load_out) begin
				ov_q <= 1'b1;
			end else if (out_ch.ready) begin
				ov_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			pb_q <= keep_now ? in_ch.data.data_byte : NEWLINE_BYTE;
		end else if (cmd.to_nl) begin
			pb_q <= NEWLINE_BYTE;
		end
		if (cmd.load_out) begin
			out_q.out_byte     <= rdata;
			out_q.seq_number   <= seq_q;
			out_q.frag_start   <= first_q;
			out_q.frag_more    <= more_q;
			out_q.frag_end     <= !more_q;
			out_q.chunk_length <= LEN_W'(fill_q);
			out_q.end_of_frame <= idx_last;
			out_q.last_of_run  <= idx_last && (!more_q || (!nl_q && !finish_q));
		end
	end

	assign out_ch.valid = ov_q;
	assign out_ch.data  = out_q;

`ifndef SYNTHESIS
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FILL_W'(MTU))
		else $error("frame fill beyond MTU");
	a_wr_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.wr |-> fill_q < FILL_W'(MTU))
		else $error("write into full frame");
	a_msg_close: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit_done && !more_q |=> fill_q == '0 && count_q == '0 && first_q)
		else $error("message state not cleared after final frame");
	a_emit_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.start_rd |-> fill_q != '0)
		else $error("emission of empty frame");
`endif
endmodule
`default_nettype wire

>>> hdl/message_fragmenter_top.sv
// Top level of the message fragmenter: controller plus datapath.
// Input: one request per idle visit; a kept byte closing no frame is written in push, then idle;
// a dropped one ending no message stays in idle. Frame emission: a start state issues the first
// store read, then one payload byte per cycle while the sink is ready, paced by its read port.
// Output register decouples the sink; a new input may be accepted while the last result waits.
// Reset (arst_n low) clears control, counters, sequence and flags; frame store is not cleared.
`default_nettype none
module message_fragmenter_top (
	input  wire logic clk,
	input  wire logic arst_n,
	mf_in_if.sink     in_ch,
	mf_out_if.source  out_ch
);
	import mf_pkg::*;

	cmd_t cmd;
	sts_t sts;

	mf_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.sts    (sts),
		.cmd    (cmd)
	);

	mf_dp u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.sts    (sts),
		.in_ch  (in_ch),
		.out_ch (out_ch)
	);
endmodule
`default_nettype wire
